FILE: rtl/core/phdps_pkg.sv
package phdps_pkg;

    localparam int TIME_WIDTH_DEF = 16;

    localparam int SAMPLE_W  = 11;
    localparam int TIME_W    = 16;
    localparam int PCT_W     = 8;
    localparam int PERIOD_W  = 16;
    localparam int DUTY_W    = 16;
    localparam int CLAMP_W   = 7;
    localparam int PROD_W    = PERIOD_W + CLAMP_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_HIGH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONLINE_MODE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_SECONDS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_SECONDS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_PERCENT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD    = 3'd6;

    localparam logic [SAMPLE_W-1:0] BAND_LOW_RST      = 11'd650;
    localparam logic [SAMPLE_W-1:0] BAND_HIGH_RST     = 11'd750;
    localparam logic [TIME_W-1:0]   ON_SECONDS_RST    = 16'd1;
    localparam logic [TIME_W-1:0]   OFF_SECONDS_RST   = 16'd1;
    localparam logic [PCT_W-1:0]    POWER_PERCENT_RST = 8'd100;
    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST    = 16'd999;

    localparam logic [PCT_W-1:0]   PCT_MAX      = 8'd100;
    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2^23
    localparam int                 RECIP_W      = 24;
    localparam logic [RECIP_W-1:0] RECIP_100    = 24'd10737419;
    localparam int                 RECIP_SHIFT  = 30;

    typedef enum logic [1:0] {
        ZONE_OK   = 2'd0,
        ZONE_LOW  = 2'd1,
        ZONE_HIGH = 2'd2
    } zone_t;

endpackage

FILE: rtl/core/ph_dosing_pump_scheduler.sv
// pH dosing pump scheduler, one update per one-second tick.
// Input stream s_*: one word per tick, carrying the pH sample and a reset-request
// flag. Output stream m_*: one word per tick with both pump enables, both PWM
// compare values, the current zone, the phase flag and the seconds left.
// Config channel cfg_*: writes register cfg_index with cfg_data; always ready.
// Write it only while the stream is idle.
// A word is registered on acceptance and the state registers update when it
// advances; the result is shown from the state registers themselves, so m_tvalid
// rises as they are loaded. Throughput is one word per cycle while m_tready is high.
// The PWM compare value is pwm_period * min(power_percent, 100) / 100, built in
// a two-register chain (product, then reciprocal multiply); s_tready stays low
// after reset and after every config write while it settles.
// Reset clears the schedule (zone in band, pumps off, compare values 0) and
// loads the config registers with their defaults.
// When m_tready is low the result word holds, the input register keeps one
// more word, and s_tready drops once that register is full.
module ph_dosing_pump_scheduler
    import phdps_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [10:0] ph_sample, [11] reset_request, [15:12] zero
    input  logic [IN_DATA_W-1:0]   s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] pump3_on, [1] pump4_on, [17:2] pump3_compare, [33:18] pump4_compare,
    // [35:34] zone_now, [36] phase_active, [52:37] seconds_left, [55:53] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [32:0] TIME_MAX = (33'd1 << TIME_WIDTH) - 33'd1;
    localparam logic [1:0]  SETTLE_CYCLES = 2'd2;

    logic [SAMPLE_W-1:0] band_low_reg;
    logic [SAMPLE_W-1:0] band_high_reg;
    logic                online_mode_reg;
    logic [TIME_W-1:0]   on_seconds_reg;
    logic [TIME_W-1:0]   off_seconds_reg;
    logic [PCT_W-1:0]    power_percent_reg;
    logic [PERIOD_W-1:0] pwm_period_reg;

    logic [1:0]          settle_reg;
    logic [CLAMP_W-1:0]  pct_clamped;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [DUTY_W-1:0]   duty_reg;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                req_reg;
    logic                out_valid_reg;
    logic                advance;

    zone_t               zone_reg, zone_next, sample_zone;
    logic                on_phase_reg, on_phase_next;
    logic [TIME_WIDTH-1:0] countdown_reg, countdown_next, countdown_dec;
    logic                pump3_en_reg, pump3_en_next;
    logic                pump4_en_reg, pump4_en_next;
    logic [DUTY_W-1:0]   pump3_duty_reg, pump3_duty_next;
    logic [DUTY_W-1:0]   pump4_duty_reg, pump4_duty_next;
    logic [SAMPLE_W-1:0] lim_lo, lim_hi;

    function automatic logic [TIME_WIDTH-1:0] time_load(input logic [TIME_W-1:0] secs);
        logic [TIME_W-1:0] v;
        v = (secs == '0) ? TIME_W'(1) : secs;
        if ({17'b0, v} > TIME_MAX)
            return TIME_MAX[TIME_WIDTH-1:0];
        return TIME_WIDTH'(v);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low_reg      <= BAND_LOW_RST;
            band_high_reg     <= BAND_HIGH_RST;
            online_mode_reg   <= 1'b0;
            on_seconds_reg    <= ON_SECONDS_RST;
            off_seconds_reg   <= OFF_SECONDS_RST;
            power_percent_reg <= POWER_PERCENT_RST;
            pwm_period_reg    <= PWM_PERIOD_RST;
            settle_reg        <= SETTLE_CYCLES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            settle_reg <= SETTLE_CYCLES;
            unique case (cfg_index)
                CFG_BAND_LOW:      band_low_reg      <= cfg_data[SAMPLE_W-1:0];
                CFG_BAND_HIGH:     band_high_reg     <= cfg_data[SAMPLE_W-1:0];
                CFG_ONLINE_MODE:   online_mode_reg   <= cfg_data[0];
                CFG_ON_SECONDS:    on_seconds_reg    <= cfg_data[TIME_W-1:0];
                CFG_OFF_SECONDS:   off_seconds_reg   <= cfg_data[TIME_W-1:0];
                CFG_POWER_PERCENT: power_percent_reg <= cfg_data[PCT_W-1:0];
                CFG_PWM_PERIOD:    pwm_period_reg    <= cfg_data[PERIOD_W-1:0];
                default:           ;
            endcase
        end
        else if (settle_reg != 2'd0)
        begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    assign pct_clamped = (power_percent_reg > PCT_MAX) ? PCT_MAX[CLAMP_W-1:0]
                                                       : power_percent_reg[CLAMP_W-1:0];
    assign scaled = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP_100};

    always_ff @(posedge clk)
    begin
        prod_reg <= {{CLAMP_W{1'b0}}, pwm_period_reg} * {{PERIOD_W{1'b0}}, pct_clamped};
        duty_reg <= scaled[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = (settle_reg == 2'd0) && (!in_valid_reg || advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            req_reg    <= s_tdata[SAMPLE_W];
        end
    end

    always_comb
    begin
        if (band_low_reg > band_high_reg)
        begin
            lim_lo = band_high_reg;
            lim_hi = band_low_reg;
        end
        else
        begin
            lim_lo = band_low_reg;
            lim_hi = band_high_reg;
        end

        priority if (sample_reg > lim_hi)
            sample_zone = ZONE_HIGH;
        else if (sample_reg < lim_lo)
            sample_zone = ZONE_LOW;
        else
            sample_zone = ZONE_OK;

        countdown_dec = (countdown_reg != '0) ? countdown_reg - TIME_WIDTH'(1) : countdown_reg;

        zone_next       = zone_reg;
        on_phase_next   = on_phase_reg;
        countdown_next  = countdown_reg;
        pump3_en_next   = pump3_en_reg;
        pump4_en_next   = pump4_en_reg;
        pump3_duty_next = pump3_duty_reg;
        pump4_duty_next = pump4_duty_reg;

        priority if (req_reg || online_mode_reg || sample_zone == ZONE_OK)
        begin
            zone_next      = ZONE_OK;
            on_phase_next  = 1'b0;
            countdown_next = '0;
            pump3_en_next  = 1'b0;
            pump4_en_next  = 1'b0;
        end
        else if (sample_zone != zone_reg || (countdown_dec == '0 && !on_phase_reg))
        begin
            // start an ON phase for the new or current zone
            zone_next      = sample_zone;
            on_phase_next  = 1'b1;
            countdown_next = time_load(on_seconds_reg);
            if (sample_zone == ZONE_LOW)
            begin
                pump3_en_next   = 1'b1;
                pump3_duty_next = duty_reg;
                pump4_en_next   = 1'b0;
            end
            else
            begin
                pump4_en_next   = 1'b1;
                pump4_duty_next = duty_reg;
                pump3_en_next   = 1'b0;
            end
        end
        else if (countdown_dec == '0)
        begin
            pump3_en_next  = 1'b0;
            pump4_en_next  = 1'b0;
            on_phase_next  = 1'b0;
            countdown_next = time_load(off_seconds_reg);
        end
        else
        begin
            countdown_next = countdown_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg       <= ZONE_OK;
            on_phase_reg   <= 1'b0;
            countdown_reg  <= '0;
            pump3_en_reg   <= 1'b0;
            pump4_en_reg   <= 1'b0;
            pump3_duty_reg <= '0;
            pump4_duty_reg <= '0;
        end
        else if (advance)
        begin
            zone_reg       <= zone_next;
            on_phase_reg   <= on_phase_next;
            countdown_reg  <= countdown_next;
            pump3_en_reg   <= pump3_en_next;
            pump4_en_reg   <= pump4_en_next;
            pump3_duty_reg <= pump3_duty_next;
            pump4_duty_reg <= pump4_duty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, 16'(countdown_reg), on_phase_reg, zone_reg,
                       pump4_duty_reg, pump3_duty_reg, pump4_en_reg, pump3_en_reg};

    a_one_pump: assert property (@(posedge clk) disable iff (!rst_n)
        !(pump3_en_reg && pump4_en_reg))
        else $error("both pumps enabled");

    a_band_idle: assert property (@(posedge clk) disable iff (!rst_n)
        zone_reg == ZONE_OK |-> !pump3_en_reg && !pump4_en_reg && countdown_reg == '0)
        else $error("schedule active while in band");

    a_pump_on_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (pump3_en_reg || pump4_en_reg) |-> on_phase_reg)
        else $error("pump enabled outside ON phase");

    a_zone_counting: assert property (@(posedge clk) disable iff (!rst_n)
        zone_reg != ZONE_OK |-> countdown_reg != '0)
        else $error("countdown idle in a dosing zone");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(zone_reg) && $stable(countdown_reg))
        else $error("schedule moved while result stalled");

endmodule
